[hw/rtl/plir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plir_pkg
// Shared types and constants for the positional list insert/remove unit.
// ----------------------------------------------------------------------------
package plir_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 2;
    localparam int LEN_W        = 7;

    localparam logic [OP_W-1:0] OP_ADD_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_AT    = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_LAST  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_LAST  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_REMOVE
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [DATA_W-1:0]  value;
    } t_cell_ctrl;

endpackage

[hw/rtl/plir_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plir_cell
// One list slot: holds an element, takes its left or right neighbor on a
// shift, loads the new value at the insert slot and taps out at a removal.
// ----------------------------------------------------------------------------
module plir_cell #(
    parameter int SW  = 6,
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  plir_pkg::t_cell_ctrl        i_ctrl,
    input  logic [SW-1:0]               i_slot,
    input  logic [plir_pkg::DATA_W-1:0] i_left,
    input  logic [plir_pkg::DATA_W-1:0] i_right,
    output logic [plir_pkg::DATA_W-1:0] o_data,
    output logic [plir_pkg::DATA_W-1:0] o_tap
);

    localparam logic [SW-1:0] MY_IDX = SW'(IDX);

    logic [plir_pkg::DATA_W-1:0] r_data;
    logic [plir_pkg::DATA_W-1:0] n_data;
    logic                        w_here;
    logic                        w_after;

    assign w_here  = (MY_IDX == i_slot);
    assign w_after = (MY_IDX > i_slot);

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.mode)
            plir_pkg::MODE_INSERT: begin
                if (w_here) begin
                    n_data = i_ctrl.value;
                end else if (w_after) begin
                    n_data = i_left;
                end
            end
            plir_pkg::MODE_REMOVE: begin
                if (w_here || w_after) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_ctrl.mode == plir_pkg::MODE_REMOVE && w_here)
                  ? r_data : '0;

endmodule

[hw/rtl/positional_list_insert_remove_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_unit
// Bounded ordered list of signed 32-bit values held in a row of cells;
// insert and remove by position shift all later cells together.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  command   start / busy        i_operation, i_position, i_value
//  result    o_done (strobe)     o_removed_value, o_status, o_length
//
//  A command is taken on any edge with start high and busy low; its result
//  appears in the next cycle for exactly one cycle. Commands may follow every
//  cycle: all cells shift together in the cycle of acceptance.
//  busy is high during reset and clears at the first edge with reset released.
//  Synchronous active-low reset clears the element count; cell contents
//  are left as they are and are never read beyond the count.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_unit #(
    parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [plir_pkg::OP_W-1:0]     i_operation,
    input  logic [plir_pkg::POS_W-1:0]    i_position,
    input  logic signed [plir_pkg::DATA_W-1:0] i_value,
    output logic                          o_done,
    output logic signed [plir_pkg::DATA_W-1:0] o_removed_value,
    output logic [plir_pkg::STAT_W-1:0]   o_status,
    output logic [plir_pkg::LEN_W-1:0]    o_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int LW = (CW > plir_pkg::LEN_W) ? CW : plir_pkg::LEN_W;
    localparam int EW = ((CW > plir_pkg::POS_W) ? CW : plir_pkg::POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [plir_pkg::DATA_W-1:0]   r_removed;
    logic [plir_pkg::STAT_W-1:0]   r_status;
    logic [plir_pkg::LEN_W-1:0]    r_length;

    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic [EW-1:0]                 w_pos;
    logic [EW-1:0]                 w_cnt;
    logic [EW-1:0]                 w_slot_e;
    logic [SW-1:0]                 w_slot;
    logic [plir_pkg::STAT_W-1:0]   w_status;
    plir_pkg::t_cell_ctrl          w_ctrl;
    logic [plir_pkg::DATA_W-1:0]   w_taken;

    logic [plir_pkg::DATA_W-1:0]   w_data [CAPACITY];
    logic [plir_pkg::DATA_W-1:0]   w_tap  [CAPACITY];

    assign w_accept = start && !r_busy;
    assign w_full   = (r_count == CAP_C);
    assign w_empty  = (r_count == '0);
    assign w_pos    = EW'(i_position);
    assign w_cnt    = EW'(r_count);

    always_comb begin
        w_status   = plir_pkg::ST_OK;
        w_slot_e   = '0;
        w_ctrl.mode  = plir_pkg::MODE_HOLD;
        w_ctrl.value = i_value;
        unique case (i_operation)
            plir_pkg::OP_ADD_FIRST: begin
                if (w_full) begin
                    w_status = plir_pkg::ST_FULL;
                end else begin
                    w_ctrl.mode = plir_pkg::MODE_INSERT;
                end
            end
            plir_pkg::OP_ADD_AT: begin
                if (w_full) begin
                    w_status = plir_pkg::ST_FULL;
                end else if (w_pos == '0 || w_pos > w_cnt + EW'(1)) begin
                    w_status = plir_pkg::ST_RANGE;
                end else begin
                    w_ctrl.mode = plir_pkg::MODE_INSERT;
                    w_slot_e    = w_pos - EW'(1);
                end
            end
            plir_pkg::OP_ADD_LAST: begin
                if (w_full) begin
                    w_status = plir_pkg::ST_FULL;
                end else begin
                    w_ctrl.mode = plir_pkg::MODE_INSERT;
                    w_slot_e    = w_cnt;
                end
            end
            plir_pkg::OP_REM_FIRST: begin
                if (w_empty) begin
                    w_status = plir_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.mode = plir_pkg::MODE_REMOVE;
                end
            end
            plir_pkg::OP_REM_AT: begin
                if (w_empty) begin
                    w_status = plir_pkg::ST_EMPTY;
                end else if (w_pos == '0 || w_pos > w_cnt) begin
                    w_status = plir_pkg::ST_RANGE;
                end else begin
                    w_ctrl.mode = plir_pkg::MODE_REMOVE;
                    w_slot_e    = w_pos - EW'(1);
                end
            end
            plir_pkg::OP_REM_LAST: begin
                if (w_empty) begin
                    w_status = plir_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.mode = plir_pkg::MODE_REMOVE;
                    w_slot_e    = w_cnt - EW'(1);
                end
            end
            default: w_status = plir_pkg::ST_OK;
        endcase
        if (!w_accept) begin
            w_ctrl.mode = plir_pkg::MODE_HOLD;
        end
    end

    assign w_slot = w_slot_e[SW-1:0];

    always_comb begin
        unique case (w_ctrl.mode)
            plir_pkg::MODE_INSERT: n_count = r_count + CW'(1);
            plir_pkg::MODE_REMOVE: n_count = r_count - CW'(1);
            default:               n_count = r_count;
        endcase
    end

    always_comb begin
        w_taken = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_taken = w_taken | w_tap[i];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [plir_pkg::DATA_W-1:0] w_left;
        logic [plir_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        plir_cell #(
            .SW  (SW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_slot  (w_slot),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= 1'b0;
            r_done  <= w_accept;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed <= w_taken;
            r_status  <= w_status;
            r_length  <= plir_pkg::LEN_W'(LW'(n_count));
        end
    end

    assign busy            = r_busy;
    assign o_done          = r_done;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_length        = r_length;

endmodule
